FILE: sv/voronoi_nearest_seed_colorer_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Voronoi nearest-seed colorer
// Shorthand for clocked implication checks that reset disables.
// ----------------------------------------------------------------------------
`ifndef VORONOI_NEAREST_SEED_COLORER_UNIT_DEFINES_SVH
`define VORONOI_NEAREST_SEED_COLORER_UNIT_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define VNSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define VNSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/vnsc_pkg.sv
// ----------------------------------------------------------------------------
// vnsc_pkg
// Shared constants, token control type and palette lookup.
// ----------------------------------------------------------------------------
package vnsc_pkg;

   // Parameter defaults
   localparam int unsigned MAX_SEEDS_DEF    = 32;
   localparam int unsigned COORD_BITS_DEF   = 10;
   localparam int unsigned PALETTE_SIZE_DEF = 7;

   // Fixed field widths
   localparam int unsigned ACTIVE_BITS      = 6;
   localparam int unsigned SLOT_BITS        = 5;
   localparam int unsigned COORD_FIELD_BITS = 10;
   localparam int unsigned COLOR_BITS       = 32;
   localparam int unsigned PAL_SEL_BITS     = 4;
   localparam int unsigned REQ_TDATA_BITS   = 32;
   localparam int unsigned RSP_TDATA_BITS   = 40;
   localparam int unsigned RSP_FIELD_BITS   = SLOT_BITS + COLOR_BITS;

   localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 6'd25;

   // Control bits that ride with each item down the chain
   typedef struct packed {
      logic valid;
      logic is_query;
      logic found;
   } tok_ctl_type;

   function automatic logic [COLOR_BITS-1:0] pal_color(input logic [PAL_SEL_BITS-1:0] sel);
      logic [COLOR_BITS-1:0] color;
      unique case (sel)
         4'd0:    color = 32'hFF3449FB;
         4'd1:    color = 32'hFF26BBB8;
         4'd2:    color = 32'hFF2FBDFA;
         4'd3:    color = 32'hFF98A583;
         4'd4:    color = 32'hFF9B86D3;
         4'd5:    color = 32'hFF7CC08E;
         4'd6:    color = 32'hFF1980FE;
         default: color = '0;
      endcase
      return color;
   endfunction

endpackage

FILE: sv/vnsc_cell.sv
// ----------------------------------------------------------------------------
// vnsc_cell
// One seed slot: holds its point, scores queries, passes the running best.
// ----------------------------------------------------------------------------
module vnsc_cell #(
   parameter int unsigned CELL_IDX     = 0,
   parameter int unsigned COORD_BITS   = vnsc_pkg::COORD_BITS_DEF,
   parameter int unsigned PALETTE_SIZE = vnsc_pkg::PALETTE_SIZE_DEF,
   parameter int unsigned IDX_BITS     = 5,
   parameter int unsigned PAL_BITS     = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic [vnsc_pkg::ACTIVE_BITS-1:0]      active_seeds,
   input  vnsc_pkg::tok_ctl_type                 in_ctl,
   input  logic [vnsc_pkg::SLOT_BITS-1:0]        in_slot,
   input  logic [COORD_BITS-1:0]                 in_x,
   input  logic [COORD_BITS-1:0]                 in_y,
   input  logic [2*COORD_BITS:0]                 in_best_d,
   input  logic [IDX_BITS-1:0]                   in_best_idx,
   input  logic [PAL_BITS-1:0]                   in_best_pal,
   output vnsc_pkg::tok_ctl_type                 out_ctl,
   output logic [vnsc_pkg::SLOT_BITS-1:0]        out_slot,
   output logic [COORD_BITS-1:0]                 out_x,
   output logic [COORD_BITS-1:0]                 out_y,
   output logic [2*COORD_BITS:0]                 out_best_d,
   output logic [IDX_BITS-1:0]                   out_best_idx,
   output logic [PAL_BITS-1:0]                   out_best_pal
);

   localparam int unsigned SQ_BITS = 2 * COORD_BITS;
   localparam logic [IDX_BITS-1:0] CELL_IDX_V = IDX_BITS'(CELL_IDX);
   localparam logic [PAL_BITS-1:0] CELL_PAL_V = PAL_BITS'(CELL_IDX % PALETTE_SIZE);

   logic [COORD_BITS-1:0] seed_x_ff, seed_x_in;
   logic [COORD_BITS-1:0] seed_y_ff, seed_y_in;

   vnsc_pkg::tok_ctl_type a_ctl_ff, a_ctl_in;
   logic [vnsc_pkg::SLOT_BITS-1:0] a_slot_ff;
   logic [COORD_BITS-1:0]          a_x_ff, a_y_ff;
   logic [SQ_BITS:0]               a_best_d_ff;
   logic [IDX_BITS-1:0]            a_best_idx_ff;
   logic [PAL_BITS-1:0]            a_best_pal_ff;
   logic [SQ_BITS-1:0]             a_sqx_ff, a_sqx_in;
   logic [SQ_BITS-1:0]             a_sqy_ff, a_sqy_in;

   vnsc_pkg::tok_ctl_type b_ctl_ff, b_ctl_in;
   logic [vnsc_pkg::SLOT_BITS-1:0] b_slot_ff;
   logic [COORD_BITS-1:0]          b_x_ff, b_y_ff;
   logic [SQ_BITS:0]               b_best_d_ff, b_best_d_in;
   logic [IDX_BITS-1:0]            b_best_idx_ff, b_best_idx_in;
   logic [PAL_BITS-1:0]            b_best_pal_ff, b_best_pal_in;

   logic                  seed_we;
   logic [COORD_BITS-1:0] dx, dy;
   logic [SQ_BITS:0]      sum_sq;
   logic                  in_range;
   logic                  take;

   // Stage A: load the slot, or square the offsets of a query
   always_comb begin
      seed_we   = advance && in_ctl.valid && !in_ctl.is_query
                  && (32'(in_slot) == CELL_IDX);
      seed_x_in = seed_we ? in_x : seed_x_ff;
      seed_y_in = seed_we ? in_y : seed_y_ff;
      dx        = (in_x >= seed_x_ff) ? (in_x - seed_x_ff) : (seed_x_ff - in_x);
      dy        = (in_y >= seed_y_ff) ? (in_y - seed_y_ff) : (seed_y_ff - in_y);
      a_sqx_in  = SQ_BITS'(dx) * SQ_BITS'(dx);
      a_sqy_in  = SQ_BITS'(dy) * SQ_BITS'(dy);
      a_ctl_in  = in_ctl;
   end

   // Stage B: sum, compare, keep the lower index on a tie
   always_comb begin
      sum_sq        = {1'b0, a_sqx_ff} + {1'b0, a_sqy_ff};
      in_range      = 32'(active_seeds) > CELL_IDX;
      take          = a_ctl_ff.valid && a_ctl_ff.is_query && in_range
                      && (!a_ctl_ff.found || (sum_sq < a_best_d_ff));
      b_ctl_in       = a_ctl_ff;
      b_ctl_in.found = a_ctl_ff.found || take;
      b_best_d_in   = take ? sum_sq     : a_best_d_ff;
      b_best_idx_in = take ? CELL_IDX_V : a_best_idx_ff;
      b_best_pal_in = take ? CELL_PAL_V : a_best_pal_ff;
   end

   always_ff @(posedge clock) begin
      seed_x_ff <= seed_x_in;
      seed_y_ff <= seed_y_in;
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
      end else if (advance) begin
         a_ctl_ff <= a_ctl_in;
         b_ctl_ff <= b_ctl_in;
      end
      if (advance) begin
         a_slot_ff     <= in_slot;
         a_x_ff        <= in_x;
         a_y_ff        <= in_y;
         a_best_d_ff   <= in_best_d;
         a_best_idx_ff <= in_best_idx;
         a_best_pal_ff <= in_best_pal;
         a_sqx_ff      <= a_sqx_in;
         a_sqy_ff      <= a_sqy_in;
         b_slot_ff     <= a_slot_ff;
         b_x_ff        <= a_x_ff;
         b_y_ff        <= a_y_ff;
         b_best_d_ff   <= b_best_d_in;
         b_best_idx_ff <= b_best_idx_in;
         b_best_pal_ff <= b_best_pal_in;
      end
   end

   assign out_ctl      = b_ctl_ff;
   assign out_slot     = b_slot_ff;
   assign out_x        = b_x_ff;
   assign out_y        = b_y_ff;
   assign out_best_d   = b_best_d_ff;
   assign out_best_idx = b_best_idx_ff;
   assign out_best_pal = b_best_pal_ff;

endmodule

FILE: sv/vnsc_out_buf.sv
// ----------------------------------------------------------------------------
// vnsc_out_buf
// Two-entry result buffer; keeps the chain moving while one result waits.
// ----------------------------------------------------------------------------
module vnsc_out_buf #(
   parameter int unsigned DATA_BITS = vnsc_pkg::RSP_FIELD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 out_ready,
   output logic                 out_valid,
   output logic [DATA_BITS-1:0] out_data,
   output logic                 room
);

   logic [1:0]           count_ff, count_in;
   logic [DATA_BITS-1:0] slot0_ff, slot0_in;
   logic [DATA_BITS-1:0] slot1_ff, slot1_in;
   logic                 pop;
   logic [1:0]           wr_pos;

   always_comb begin
      pop      = count_ff != 2'd0 && out_ready;
      wr_pos   = count_ff - {1'b0, pop};
      slot0_in = pop ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      if (push && wr_pos == 2'd0) begin
         slot0_in = push_data;
      end
      if (push && wr_pos == 2'd1) begin
         slot1_in = push_data;
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign out_valid = count_ff != 2'd0;
   assign out_data  = slot0_ff;
   assign room      = !count_ff[1];

endmodule

FILE: sv/voronoi_nearest_seed_colorer_unit.sv
// ----------------------------------------------------------------------------
// voronoi_nearest_seed_colorer_unit
// Nearest-seed search over a row of seed cells, with palette color output.
// ----------------------------------------------------------------------------
// Throughput: one item (load or query) per cycle while the result buffer
//   has room; each seed cell is a two-stage pipeline (square, then sum and
//   compare) shared by all items, and the buffer follows the last cell.
// Reset: active_seeds returns to 25, the chain and result buffer empty;
//   seed points are not cleared and hold garbage until loaded.
// ----------------------------------------------------------------------------
module voronoi_nearest_seed_colorer_unit #(
   parameter int unsigned MAX_SEEDS    = vnsc_pkg::MAX_SEEDS_DEF,
   parameter int unsigned COORD_BITS   = vnsc_pkg::COORD_BITS_DEF,
   parameter int unsigned PALETTE_SIZE = vnsc_pkg::PALETTE_SIZE_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: seed_slot[4:0], x_coord[14:5], y_coord[24:15], zero pad [31:25]
   input  logic [vnsc_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // tuser: mode (0 load seed, 1 classify pixel)
   input  logic                                  req_tuser,
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: nearest_seed[4:0], pixel_color[36:5], zero pad [39:37]
   output logic [vnsc_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // configuration
   input  logic                                  csr_wr_en,
   input  logic [vnsc_pkg::ACTIVE_BITS-1:0]      csr_wr_data
);

   localparam int unsigned IDX_BITS = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
   localparam int unsigned PAL_BITS = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
   localparam int unsigned D_BITS   = 2 * COORD_BITS + 1;
   localparam int unsigned SB       = vnsc_pkg::SLOT_BITS;
   localparam int unsigned CFB      = vnsc_pkg::COORD_FIELD_BITS;
   localparam int unsigned PAD_BITS = vnsc_pkg::RSP_TDATA_BITS - vnsc_pkg::RSP_FIELD_BITS;

   // Active seed count register
   logic [vnsc_pkg::ACTIVE_BITS-1:0] active_ff, active_in;

   // Chain links: element 0 is fed from the request port, element i+1 is
   // the output of cell i, and the last element feeds the result buffer.
   vnsc_pkg::tok_ctl_type ctl_chain  [0:MAX_SEEDS];
   logic [SB-1:0]         slot_chain [0:MAX_SEEDS];
   logic [COORD_BITS-1:0] x_chain    [0:MAX_SEEDS];
   logic [COORD_BITS-1:0] y_chain    [0:MAX_SEEDS];
   logic [D_BITS-1:0]     d_chain    [0:MAX_SEEDS];
   logic [IDX_BITS-1:0]   idx_chain  [0:MAX_SEEDS];
   logic [PAL_BITS-1:0]   pal_chain  [0:MAX_SEEDS];

   logic                                 advance;
   logic                                 push;
   logic [vnsc_pkg::RSP_FIELD_BITS-1:0]  push_data;
   logic [vnsc_pkg::RSP_FIELD_BITS-1:0]  buf_data;
   logic [vnsc_pkg::COLOR_BITS-1:0]      color;

   // Take each enabled write; software must write only while idle, unenforced
   always_comb begin
      active_in = csr_wr_en ? csr_wr_data : active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= vnsc_pkg::ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   // The whole chain steps together; it halts only while the result buffer
   // is full, so one waiting result never blocks new requests.
   assign req_tready = advance;

   // Inject the request at the head of the chain. A query starts with no
   // candidate; if no cell is active it leaves with index 0 and palette 0.
   always_comb begin
      ctl_chain[0].valid    = req_tvalid;
      ctl_chain[0].is_query = req_tuser;
      ctl_chain[0].found    = 1'b0;
      slot_chain[0]         = req_tdata[SB-1:0];
      x_chain[0]            = COORD_BITS'(req_tdata[SB +: CFB]);
      y_chain[0]            = COORD_BITS'(req_tdata[SB+CFB +: CFB]);
      d_chain[0]            = '0;
      idx_chain[0]          = '0;
      pal_chain[0]          = '0;
   end

   // One cell per seed slot. Loads travel the same chain as queries, so a
   // query always sees exactly the loads accepted before it.
   for (genvar i = 0; i < MAX_SEEDS; i++) begin : g_cell
      vnsc_cell #(
         .CELL_IDX     (i),
         .COORD_BITS   (COORD_BITS),
         .PALETTE_SIZE (PALETTE_SIZE),
         .IDX_BITS     (IDX_BITS),
         .PAL_BITS     (PAL_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .active_seeds (active_ff),
         .in_ctl       (ctl_chain[i]),
         .in_slot      (slot_chain[i]),
         .in_x         (x_chain[i]),
         .in_y         (y_chain[i]),
         .in_best_d    (d_chain[i]),
         .in_best_idx  (idx_chain[i]),
         .in_best_pal  (pal_chain[i]),
         .out_ctl      (ctl_chain[i+1]),
         .out_slot     (slot_chain[i+1]),
         .out_x        (x_chain[i+1]),
         .out_y        (y_chain[i+1]),
         .out_best_d   (d_chain[i+1]),
         .out_best_idx (idx_chain[i+1]),
         .out_best_pal (pal_chain[i+1])
      );
   end

   // Drop loads at the tail; push finished queries with their palette color.
   // The palette index was carried along, so no modulo is needed here.
   always_comb begin
      push      = advance && ctl_chain[MAX_SEEDS].valid && ctl_chain[MAX_SEEDS].is_query;
      color     = vnsc_pkg::pal_color(vnsc_pkg::PAL_SEL_BITS'(pal_chain[MAX_SEEDS]));
      push_data = {color, SB'(idx_chain[MAX_SEEDS])};
   end

   vnsc_out_buf #(
      .DATA_BITS (vnsc_pkg::RSP_FIELD_BITS)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (buf_data),
      .room      (advance)
   );

   assign rsp_tdata = {{PAD_BITS{1'b0}}, buf_data};

endmodule

FILE: sv/vnsc_checker.sv
// ----------------------------------------------------------------------------
// vnsc_checker
// Port-level checks on the nearest-seed colorer, bound to the top level.
// ----------------------------------------------------------------------------
`include "voronoi_nearest_seed_colorer_unit_defines.svh"

module vnsc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [vnsc_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);

   // A stalled result holds its value
   `VNSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed or vanished")

   // Requests stall only while results are backed up at the output
   `VNSC_ASSERT_NOW(a_stall_has_rsp, clock, reset, !req_tready, rsp_tvalid, "request stalled with no result pending")

   // Colors are opaque palette entries or all zero
   `VNSC_ASSERT_NOW(a_color_alpha, clock, reset, rsp_tvalid, rsp_tdata[36:29] == 8'hFF || rsp_tdata[36:5] == 32'h0, "color outside palette")

   // Pad bits above the color stay zero
   `VNSC_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[39:37] == 3'b000, "nonzero pad bits")

endmodule

bind voronoi_nearest_seed_colorer_unit vnsc_checker u_vnsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: verif/voronoi_nearest_seed_colorer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voronoi_nearest_seed_colorer_unit_tb
// Streams seed loads and pixel queries into the colorer and checks every
// response against an in-bench nearest-seed search. Phases differ in the
// active seed count and in how often each side idles.
// ----------------------------------------------------------------------------
module voronoi_nearest_seed_colorer_unit_tb;

   localparam int unsigned TABLE_DEPTH  = vnsc_pkg::MAX_SEEDS_DEF;
   localparam int unsigned PALETTE_LEN  = vnsc_pkg::PALETTE_SIZE_DEF;
   localparam int unsigned PIPE_LATENCY = 2 * TABLE_DEPTH + 1;
   localparam int unsigned SETTLE_CYCLES = 2 * PIPE_LATENCY;
   localparam int          TIMEOUT_NS   = 2_000_000;
   localparam logic [9:0]  COORD_MAX    = 10'd1023;

   localparam logic [31:0] SEED_PALETTE [0:6] = '{
      32'hFF3449FB, 32'hFF26BBB8, 32'hFF2FBDFA, 32'hFF98A583,
      32'hFF9B86D3, 32'hFF7CC08E, 32'hFF1980FE
   };

   typedef enum logic {
      MODE_LOAD     = 1'b0,
      MODE_CLASSIFY = 1'b1
   } req_mode_type;

   typedef struct packed {
      req_mode_type mode;
      logic [4:0]   slot;
      logic [9:0]   x;
      logic [9:0]   y;
   } seed_req_type;

   typedef struct packed {
      logic [4:0]  seed;
      logic [31:0] color;
   } pixel_result_type;

   // DUT ports
   logic                                 clock       = 1'b0;
   logic                                 reset       = 1'b1;
   logic                                 req_tvalid  = 1'b0;
   logic                                 req_tready;
   logic [vnsc_pkg::REQ_TDATA_BITS-1:0]  req_tdata   = '0;
   logic                                 req_tuser   = 1'b0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready  = 1'b0;
   logic [vnsc_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata;
   logic                                 csr_wr_en   = 1'b0;
   logic [vnsc_pkg::ACTIVE_BITS-1:0]     csr_wr_data = '0;

   // Stimulus side: items waiting for the driver, and the seed layout they build
   seed_req_type    pending_items[$];
   logic [9:0]      gen_x [0:TABLE_DEPTH-1];
   logic [9:0]      gen_y [0:TABLE_DEPTH-1];
   int unsigned     items_queued   = 0;
   int unsigned     send_idle_pct  = 0;
   int unsigned     rsp_stall_pct  = 0;

   // Checking side: predicted seed table, active count and pending answers
   logic [9:0]       seed_x_tab [0:TABLE_DEPTH-1];
   logic [9:0]       seed_y_tab [0:TABLE_DEPTH-1];
   logic [5:0]       cur_active;
   pixel_result_type pixel_result_q[$];
   int unsigned      items_accepted = 0;
   bit               req_accepted   = 1'b0;
   int unsigned      error_count    = 0;

   voronoi_nearest_seed_colorer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Brute-force nearest seed over the active slots, squared distance,
   // strict less-than so the lowest index keeps a tie.
   function automatic pixel_result_type classify_pixel(input logic [9:0] px,
                                                       input logic [9:0] py);
      int unsigned      span;
      int unsigned      best_idx;
      int unsigned      best_dist;
      int unsigned      dx;
      int unsigned      dy;
      int unsigned      sq_dist;
      pixel_result_type res;
      span      = (cur_active > TABLE_DEPTH) ? TABLE_DEPTH : cur_active;
      best_idx  = 0;
      best_dist = 0;
      for (int unsigned s = 0; s < span; s++) begin
         dx      = (px > seed_x_tab[s]) ? px - seed_x_tab[s] : seed_x_tab[s] - px;
         dy      = (py > seed_y_tab[s]) ? py - seed_y_tab[s] : seed_y_tab[s] - py;
         sq_dist = dx * dx + dy * dy;
         if (s == 0 || sq_dist < best_dist) begin
            best_dist = sq_dist;
            best_idx  = s;
         end
      end
      // zero active seeds falls through to slot 0 and palette entry 0
      res.seed  = best_idx[4:0];
      res.color = SEED_PALETTE[best_idx % PALETTE_LEN];
      return res;
   endfunction

   // Coordinates lean toward the edges of the range now and then.
   function automatic logic [9:0] rand_coord();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll == 0) begin
         return 10'd0;
      end else if (roll == 1) begin
         return COORD_MAX;
      end
      return 10'($urandom_range(COORD_MAX));
   endfunction

   task automatic queue_load(input logic [4:0] slot, input logic [9:0] x, input logic [9:0] y);
      seed_req_type it;
      it.mode = MODE_LOAD;
      it.slot = slot;
      it.x    = x;
      it.y    = y;
      pending_items.push_back(it);
      gen_x[slot] = x;
      gen_y[slot] = y;
      items_queued++;
   endtask

   // The slot field is don't-care on a query; randomize it anyway.
   task automatic queue_classify(input logic [9:0] x, input logic [9:0] y);
      seed_req_type it;
      it.mode = MODE_CLASSIFY;
      it.slot = 5'($urandom_range(TABLE_DEPTH - 1));
      it.x    = x;
      it.y    = y;
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Mostly queries; loads and queries are steered onto existing seeds so
   // that duplicate seeds and equidistant pixels (ties) show up often.
   task automatic queue_random_item();
      int unsigned roll;
      int unsigned peer;
      logic [9:0]  x;
      logic [9:0]  y;
      peer = $urandom_range(TABLE_DEPTH - 1);
      roll = $urandom_range(99);
      if (roll < 30) begin
         if (roll < 5) begin
            x = gen_x[peer];
            y = gen_y[peer];
         end else if (roll < 10) begin
            x = (gen_x[peer] > COORD_MAX - 2) ? gen_x[peer] - 10'd2 : gen_x[peer] + 10'd2;
            y = gen_y[peer];
         end else begin
            x = rand_coord();
            y = rand_coord();
         end
         queue_load(5'($urandom_range(TABLE_DEPTH - 1)), x, y);
      end else begin
         if (roll < 45) begin
            x = gen_x[peer];
            y = gen_y[peer];
         end else if (roll < 60) begin
            x = (gen_x[peer] == COORD_MAX) ? COORD_MAX - 10'd1 : gen_x[peer] + 10'd1;
            y = gen_y[peer];
         end else begin
            x = rand_coord();
            y = rand_coord();
         end
         queue_classify(x, y);
      end
   endtask

   // Hold until every queued item is taken and every answer is back, then
   // give loads still travelling down the seed chain time to land.
   task automatic drain_and_settle();
      while (items_accepted != items_queued || pixel_result_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_active(input logic [5:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_mixed_phase(input logic [5:0] active, input int unsigned send_pct,
                                  input int unsigned stall_pct, input int unsigned count);
      drain_and_settle();
      write_active(active);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) queue_random_item();
   endtask

   // Driver: advance to the next item only once the current one is taken;
   // otherwise hold tvalid and tdata steady.
   always @(negedge clock) begin : req_driver
      seed_req_type it;
      if (!reset && (!req_tvalid || req_accepted)) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            it = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {7'd0, it.y, it.x, it.slot};
            req_tuser  <= it.mode;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall at the phase's rate.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Monitor: track register writes, predict on each accepted request and
   // compare each accepted response with the oldest prediction.
   always @(posedge clock) begin : monitor
      pixel_result_type want;
      logic [4:0]       got_seed;
      logic [31:0]      got_color;
      if (reset) begin
         cur_active   = vnsc_pkg::ACTIVE_RESET;
         req_accepted = 1'b0;
      end else begin
         if (csr_wr_en) begin
            cur_active = csr_wr_data;
         end
         req_accepted = req_tvalid && req_tready;
         if (req_accepted) begin
            items_accepted++;
            if (req_tuser == MODE_CLASSIFY) begin
               pixel_result_q.push_back(classify_pixel(req_tdata[14:5], req_tdata[24:15]));
            end else begin
               seed_x_tab[req_tdata[4:0]] = req_tdata[14:5];
               seed_y_tab[req_tdata[4:0]] = req_tdata[24:15];
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got_seed  = rsp_tdata[4:0];
            got_color = rsp_tdata[36:5];
            if (pixel_result_q.size() == 0) begin
               $error("nearest_seed: no item expected, got %0d (pixel_color %h)",
                      got_seed, got_color);
               error_count++;
            end else begin
               want = pixel_result_q.pop_front();
               if (got_seed !== want.seed) begin
                  $error("nearest_seed: expected %0d, got %0d", want.seed, got_seed);
                  error_count++;
               end
               if (got_color !== want.color) begin
                  $error("pixel_color: expected %h, got %h", want.color, got_color);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: four corner seeds, queries at each corner and the center,
      // an overwritten slot, duplicate seeds and an equidistant pixel.
      write_active(6'd4);
      queue_load(5'd0, 10'd0, 10'd0);
      queue_load(5'd1, COORD_MAX, COORD_MAX);
      queue_load(5'd2, 10'd0, COORD_MAX);
      queue_load(5'd3, COORD_MAX, 10'd0);
      queue_classify(10'd0, 10'd0);
      queue_classify(COORD_MAX, COORD_MAX);
      queue_classify(10'd0, COORD_MAX);
      queue_classify(COORD_MAX, 10'd0);
      queue_classify(10'd511, 10'd511);
      queue_classify(10'd512, 10'd512);
      queue_classify(10'd511, 10'd512);
      // slot 3 now duplicates slot 2: the lower index must win
      queue_load(5'd3, 10'd0, COORD_MAX);
      queue_classify(10'd0, COORD_MAX);
      queue_classify(10'd100, 10'd900);
      // pixel midway between slot 0 and slot 1
      queue_load(5'd1, 10'd2, 10'd0);
      queue_classify(10'd1, 10'd0);

      // No active seeds: every query lands on slot 0
      drain_and_settle();
      write_active(6'd0);
      queue_classify(10'd0, 10'd0);
      queue_classify(COORD_MAX, COORD_MAX);
      queue_classify(rand_coord(), rand_coord());

      // Fill the whole table before any wider search
      drain_and_settle();
      write_active(6'd32);
      for (int unsigned s = 0; s < TABLE_DEPTH; s++) begin
         queue_load(5'(s), rand_coord(), rand_coord());
      end
      repeat (130) queue_random_item();

      // Random phases: full range of active counts, including one beyond the
      // table (saturates), under each idling pattern
      run_mixed_phase(6'd63, 76, 0, 130);
      run_mixed_phase(6'd1, 0, 76, 130);
      run_mixed_phase(6'd25, 19, 19, 130);
      run_mixed_phase(6'd32, 0, 0, 130);
      run_mixed_phase(6'd17, 76, 0, 130);
      run_mixed_phase(6'($urandom_range(31, 2)), 0, 76, 130);
      run_mixed_phase(6'($urandom_range(32, 1)), 19, 19, 130);
      run_mixed_phase(6'd32, 19, 19, 130);

      drain_and_settle();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a missing response ends up here
   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

endmodule
